/* rtl/core/gbp_pkg.sv */
// Goertzel bin power: shared types and constants.
// Controller states, datapath command and status structs, field widths.
// No dependencies.
`default_nettype none

package gbp_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEFF_W    = 18;
  localparam int POWER_W    = 62;
  localparam int COUNT_W    = 13;
  localparam int DIGIT_W    = 16;
  localparam int FRAC_SHIFT = 16;
  localparam int ROUND_HALF = 32768;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REC,
    ST_SQ1,
    ST_SQ1_W,
    ST_SQ2_W,
    ST_CS_W,
    ST_CR_W,
    ST_OUT
  } gbp_state_t;

  // multiplier operand selection
  typedef enum logic [1:0] {
    SEL_CS1,
    SEL_SQ1,
    SEL_SQ2,
    SEL_CROSS
  } gbp_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     mul_start;
    gbp_sel_t mul_sel;
    logic     rec_upd;
    logic     acc_load;
    logic     acc_add;
    logic     acc_sub;
    logic     out_load;
  } gbp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic last;
    logic out_hold;
  } gbp_sts_t;

endpackage

`default_nettype wire

/* rtl/core/gbp_mul.sv */
// Goertzel bin power: shared signed multiplier, one 16-bit digit of b per cycle.
// Shift-add over NDIG digits, top digit signed. Uses gbp_pkg.
`default_nettype none

module gbp_mul #(
  parameter int A_W  = 58,
  parameter int NDIG = 3
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  input  wire logic [A_W-1:0]                      a_in,
  input  wire logic [NDIG*gbp_pkg::DIGIT_W-1:0]    b_in,
  output logic                                     done,
  output logic [A_W+NDIG*gbp_pkg::DIGIT_W-1:0]     prod
);
  import gbp_pkg::*;

  localparam int BW    = NDIG * DIGIT_W;
  localparam int HW    = A_W + DIGIT_W + 1;
  localparam int PRW   = HW + BW;
  localparam int CNT_W = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam logic [CNT_W-1:0] LAST_DIG = CNT_W'(NDIG - 1);

  logic signed [A_W-1:0] a_r, a_nxt;
  logic [PRW-1:0]        prod_r, prod_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;

  logic                  top_dig;
  logic signed [DIGIT_W:0] dig_s;
  logic signed [HW-1:0]  partial;
  logic signed [HW-1:0]  sum;

  always_comb begin
    top_dig = (cnt_r == LAST_DIG);
    dig_s   = {top_dig & prod_r[DIGIT_W-1], prod_r[DIGIT_W-1:0]};
    partial = a_r * dig_s;
    sum     = $signed(prod_r[PRW-1:BW]) + partial;

    a_nxt    = a_r;
    prod_nxt = prod_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = a_in;
      prod_nxt = {{HW{1'b0}}, b_in};
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      prod_nxt = {{DIGIT_W{sum[HW-1]}}, sum, prod_r[BW-1:DIGIT_W]};
      cnt_nxt  = cnt_r + CNT_W'(1);
      if (top_dig) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    prod_r <= prod_nxt;
  end

  assign done = done_r;
  assign prod = prod_r[A_W+BW-1:0];

`ifndef NO_ASSERTIONS
  a_no_restart_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && busy_r))
    else $error("multiplier restarted while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("multiplier done while still stepping");
`endif

endmodule

`default_nettype wire

/* rtl/core/gbp_datapath.sv */
// Goertzel bin power: datapath with recurrence state, power accumulator
// and output register. Uses gbp_pkg and gbp_mul.
`default_nettype none

module gbp_datapath #(
  parameter int STATE_WIDTH = 40,
  parameter int MAX_BLOCK   = 4096
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire gbp_pkg::gbp_cmd_t               cmd,
  output gbp_pkg::gbp_sts_t                    sts,
  input  wire logic                            cfg_we,
  input  wire logic [gbp_pkg::COEFF_W-1:0]     cfg_coeff,
  input  wire logic [gbp_pkg::SAMPLE_W-1:0]    in_sample,
  input  wire logic                            in_last_sample,
  input  wire logic                            out_stall,
  output logic                                 out_valid,
  output logic [gbp_pkg::POWER_W-1:0]          out_power,
  output logic [gbp_pkg::COUNT_W-1:0]          out_block_count
);
  import gbp_pkg::*;

  localparam int SW   = STATE_WIDTH;
  localparam int CW   = COEFF_W;
  localparam int NB   = (SW + DIGIT_W - 1) / DIGIT_W;
  localparam int BW   = NB * DIGIT_W;
  localparam int AW   = SW + CW;
  localparam int MPW  = AW + BW;
  localparam int XW   = 2 * SW + CW;
  localparam int PWW  = 2 * SW + 3;
  localparam int RSW  = SW + 5;
  localparam int CNTW = $clog2(MAX_BLOCK + 1);

  localparam logic signed [AW:0]    RND_REC = (AW + 1)'(ROUND_HALF);
  localparam logic signed [XW:0]    RND_X   = (XW + 1)'(ROUND_HALF);
  localparam logic signed [RSW-1:0] S_MAX   = ((RSW)'(1) << (SW - 1)) - (RSW)'(1);
  localparam logic signed [RSW-1:0] S_MIN   = -S_MAX - (RSW)'(1);
  localparam logic [CNTW-1:0]       CNT_TOP = CNTW'(MAX_BLOCK);

  logic signed [CW-1:0]       coeff_r, coeff_nxt;
  logic signed [SAMPLE_W-1:0] x_r, x_nxt;
  logic                       last_r, last_nxt;
  logic signed [SW-1:0]       s1_r, s1_nxt;
  logic signed [SW-1:0]       s2_r, s2_nxt;
  logic [CNTW-1:0]            cnt_r, cnt_nxt;
  logic signed [PWW-1:0]      acc_r, acc_nxt;
  logic [POWER_W-1:0]         power_r, power_nxt;
  logic [COUNT_W-1:0]         count_r, count_nxt;
  logic                       out_valid_r, out_valid_nxt;

  logic [AW-1:0]              mul_a;
  logic [BW-1:0]              mul_b;
  logic                       mul_done;
  logic [MPW-1:0]             mul_p;

  logic signed [AW:0]         rec_sum;
  logic signed [AW-FRAC_SHIFT:0] rec_t;
  logic signed [RSW-1:0]      s0_full;
  logic signed [SW-1:0]       s0_sat;
  logic signed [PWW-1:0]      sq;
  logic signed [XW:0]         x_sum;
  logic signed [PWW-1:0]      cross_rnd;
  logic [POWER_W-1:0]         power_clamp;
  logic [CNTW-1:0]            cnt_inc;
  logic [CNTW+COUNT_W-1:0]    cnt_wide;

  gbp_mul #(
    .A_W  (AW),
    .NDIG (NB)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a_in  (mul_a),
    .b_in  (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  always_comb begin
    case (cmd.mul_sel)
      SEL_CS1: begin
        mul_a = AW'(s1_r);
        mul_b = BW'(coeff_r);
      end
      SEL_SQ1: begin
        mul_a = AW'(s1_r);
        mul_b = BW'(s1_r);
      end
      SEL_SQ2: begin
        mul_a = AW'(s2_r);
        mul_b = BW'(s2_r);
      end
      SEL_CROSS: begin
        mul_a = mul_p[AW-1:0];
        mul_b = BW'(s2_r);
      end
      default: begin
        mul_a = AW'(s1_r);
        mul_b = BW'(coeff_r);
      end
    endcase
  end

  always_comb begin
    // recurrence: x + round(c*s1) - s2, saturated
    rec_sum = (AW + 1)'($signed(mul_p[AW-1:0])) + RND_REC;
    rec_t   = rec_sum[AW:FRAC_SHIFT];
    s0_full = RSW'(x_r) + RSW'(rec_t) - RSW'(s2_r);
    if (s0_full > S_MAX) begin
      s0_sat = S_MAX[SW-1:0];
    end else if (s0_full < S_MIN) begin
      s0_sat = S_MIN[SW-1:0];
    end else begin
      s0_sat = s0_full[SW-1:0];
    end

    sq        = PWW'($signed(mul_p[2*SW-1:0]));
    x_sum     = (XW + 1)'($signed(mul_p[XW-1:0])) + RND_X;
    cross_rnd = x_sum[XW:FRAC_SHIFT];

    if (acc_r[PWW-1]) begin
      power_clamp = '0;
    end else if (|acc_r[PWW-2:POWER_W]) begin
      power_clamp = '1;
    end else begin
      power_clamp = acc_r[POWER_W-1:0];
    end

    cnt_inc  = (cnt_r < CNT_TOP) ? cnt_r + CNTW'(1) : cnt_r;
    cnt_wide = (CNTW + COUNT_W)'(cnt_r);
  end

  always_comb begin
    coeff_nxt     = cfg_we ? cfg_coeff : coeff_r;
    x_nxt         = cmd.load_in ? in_sample : x_r;
    last_nxt      = cmd.load_in ? in_last_sample : last_r;
    s1_nxt        = s1_r;
    s2_nxt        = s2_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    power_nxt     = power_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (cmd.rec_upd) begin
      s2_nxt  = s1_r;
      s1_nxt  = s0_sat;
      cnt_nxt = cnt_inc;
    end
    if (cmd.acc_load) begin
      acc_nxt = sq;
    end else if (cmd.acc_add) begin
      acc_nxt = acc_r + sq;
    end else if (cmd.acc_sub) begin
      acc_nxt = acc_r - cross_rnd;
    end
    if (cmd.out_load) begin
      power_nxt     = power_clamp;
      count_nxt     = cnt_wide[COUNT_W-1:0];
      out_valid_nxt = 1'b1;
      s1_nxt        = '0;
      s2_nxt        = '0;
      cnt_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_r     <= '0;
      s1_r        <= '0;
      s2_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      coeff_r     <= coeff_nxt;
      s1_r        <= s1_nxt;
      s2_r        <= s2_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    last_r  <= last_nxt;
    acc_r   <= acc_nxt;
    power_r <= power_nxt;
    count_r <= count_nxt;
  end

  assign sts.mul_done     = mul_done;
  assign sts.last         = last_r;
  assign sts.out_hold     = out_valid_r && out_stall;
  assign out_valid        = out_valid_r;
  assign out_power        = power_r;
  assign out_block_count  = count_r;

`ifndef NO_ASSERTIONS
  a_clear_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (s1_r == '0) && (s2_r == '0) && (cnt_r == '0) && out_valid_r)
    else $error("state not cleared after block result");

  a_cnt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_TOP)
    else $error("sample counter past block limit");
`endif

endmodule

`default_nettype wire

/* rtl/core/gbp_ctrl.sv */
// Goertzel bin power: controller state machine.
// Sequences the shared multiplier and datapath updates. Uses gbp_pkg.
`default_nettype none

module gbp_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire gbp_pkg::gbp_sts_t sts,
  output gbp_pkg::gbp_cmd_t      cmd
);
  import gbp_pkg::*;

  gbp_state_t st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt      = st_r;
    cmd         = '0;
    cmd.mul_sel = SEL_CS1;
    in_stall    = (st_r != ST_IDLE);
    case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in   = 1'b1;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = SEL_CS1;
          st_nxt        = ST_REC;
        end
      end
      ST_REC: begin
        if (sts.mul_done) begin
          cmd.rec_upd = 1'b1;
          st_nxt      = sts.last ? ST_SQ1 : ST_IDLE;
        end
      end
      ST_SQ1: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = SEL_SQ1;
        st_nxt        = ST_SQ1_W;
      end
      ST_SQ1_W: begin
        if (sts.mul_done) begin
          cmd.acc_load  = 1'b1;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = SEL_SQ2;
          st_nxt        = ST_SQ2_W;
        end
      end
      ST_SQ2_W: begin
        if (sts.mul_done) begin
          cmd.acc_add   = 1'b1;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = SEL_CS1;
          st_nxt        = ST_CS_W;
        end
      end
      ST_CS_W: begin
        if (sts.mul_done) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = SEL_CROSS;
          st_nxt        = ST_CR_W;
        end
      end
      ST_CR_W: begin
        if (sts.mul_done) begin
          cmd.acc_sub = 1'b1;
          st_nxt      = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!sts.out_hold) begin
          cmd.out_load = 1'b1;
          st_nxt       = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_idle_no_done: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE) |-> !sts.mul_done)
    else $error("multiplier result left unused");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !sts.out_hold)
    else $error("result register overwritten while held");
`endif

endmodule

`default_nettype wire

/* rtl/core/goertzel_bin_power.sv */
// Goertzel bin power: top level joining controller and datapath.
// Uses gbp_pkg, gbp_ctrl, gbp_datapath (with gbp_mul).
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  in_sample[15:0], in_last_sample
//   out_     output     out_valid/out_stall  out_power[61:0], out_block_count[12:0]
//   cfg_     input      cfg_valid/cfg_ready  cfg_coeff[17:0]
//
// Each sample runs through the shared multiplier, which takes one 16-bit digit per
// cycle; in_stall holds off the next sample until the recurrence is updated.
// A last sample adds the power terms: s1*s1, s2*s2, then c*s1 and its product with s2.
// Reset is synchronous: clears the recurrence, the counter and coeff (to 0).
// Results sit in an output register; samples keep being taken while it is held,
// and only the next block's result waits for the transfer.
`default_nettype none

module goertzel_bin_power #(
  parameter int STATE_WIDTH = 40,
  parameter int MAX_BLOCK   = 4096
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [gbp_pkg::SAMPLE_W-1:0]  in_sample,
  input  wire logic                          in_last_sample,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [gbp_pkg::POWER_W-1:0]        out_power,
  output logic [gbp_pkg::COUNT_W-1:0]        out_block_count,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [gbp_pkg::COEFF_W-1:0]   cfg_coeff
);
  import gbp_pkg::*;

  gbp_cmd_t cmd;
  gbp_sts_t sts;

  assign cfg_ready = 1'b1;

  gbp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  gbp_datapath #(
    .STATE_WIDTH (STATE_WIDTH),
    .MAX_BLOCK   (MAX_BLOCK)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_coeff       (cfg_coeff),
    .in_sample       (in_sample),
    .in_last_sample  (in_last_sample),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_power       (out_power),
    .out_block_count (out_block_count)
  );

endmodule

`default_nettype wire
